// ===== design/bcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants, register indexes and state codes of the barometer block.
package bcs_pkg;

   localparam int WORD_W    = 16;
   localparam int WEIGHT_W  = 17;
   localparam int CSR_IDX_W = 3;
   localparam int RAW_SHIFT = 6;
   localparam int SAMPLE_W  = WORD_W - RAW_SHIFT;

   // Working widths of the serial datapath (sum, cross and scaled terms signed)
   localparam int ACC_W    = 39;   // full sum S
   localparam int CROSS_W  = 28;   // b1 scaled plus c12*T
   localparam int SCALED_W = 46;   // 65*S plus bias
   localparam int REM_W    = 42;   // dividend below 65536 * divisor
   localparam int DVS_W    = 41;   // divisor shifted to the top quotient bit
   localparam int BLEND_W  = 32;
   localparam int CNT_W    = 5;

   // b1 = (w & 0x1FFF) - 24576; 24576 = 0x6000, so the value is 0xA000 | low 13 bits
   localparam int PGAIN_FRAC_W = 13;
   localparam logic [WORD_W-PGAIN_FRAC_W-1:0] PGAIN_BIAS_HI = 3'b101;

   localparam int     SCALE_NUM_SHIFT = 6;   // 65 = 64 + 1
   localparam longint SCALE_DEN       = 64'd1023 * 64'd65536;
   localparam longint KPA_OFFSET      = 64'd12800;

   localparam logic signed [SCALED_W-1:0] SCALE_BIAS =
      SCALED_W'(SCALE_DEN / 2 + KPA_OFFSET * SCALE_DEN);
   localparam logic [SCALED_W-1:0] SAT_LIMIT = SCALED_W'(SCALE_DEN * 64'd65536);
   localparam logic [DVS_W-1:0]    DVS_START = DVS_W'(SCALE_DEN << (WORD_W - 1));

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
   localparam logic [BLEND_W:0]    BLEND_HALF = (BLEND_W + 1)'(32768);

   localparam logic [CNT_W-1:0] MULT_LAST   = CNT_W'(2 * SAMPLE_W - 1);
   localparam logic [CNT_W-1:0] T_STEPS     = CNT_W'(SAMPLE_W);
   localparam logic [CNT_W-1:0] WORD_LAST   = CNT_W'(WORD_W - 1);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_COEFF = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CROSS_COEFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SANE_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SANE_HIGH    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_WEIGHT  = 3'd6;

   localparam logic [WORD_W-1:0]   SANE_LOW_RESET    = 16'd23808;
   localparam logic [WORD_W-1:0]   SANE_HIGH_RESET   = 16'd27392;
   localparam logic [WEIGHT_W-1:0] KEEP_WEIGHT_RESET = 17'd58982;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MULT   = 7'b0000010,
      ST_SCALE  = 7'b0000100,
      ST_DIVIDE = 7'b0001000,
      ST_JUDGE  = 7'b0010000,
      ST_BLEND  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

endpackage

// ===== design/barometer_compensate_smooth.sv =====
`timescale 1ns / 1ps
// Top level: bit-serial pressure compensation, sanity check and smoothing.
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_tvalid/req_tready  tdata: pressure_word, temperature_word
//  rsp      out        rsp_tvalid/rsp_tready  tdata: estimate, reading;
//                                             tuser: reading_sane, recalibrate
//  csr      in         csr_wr_en              csr_index, csr_wdata
//
//  A request runs through 20 shift-add steps, 1 scale, 16 shift-subtract steps, 1 judge
//  and 1 finish step to the result register, with 16 more shift-add steps when the
//  reading is blended; the serial multiplier and divider set these step counts.
//  The next request is taken the cycle after the result register is loaded.
//  A result not yet taken holds the finish step; the next request is still worked on.
//  Reset is synchronous: estimate clears to zero, configuration registers take their defaults.
module barometer_compensate_smooth (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] pressure_word, [31:16] temperature_word
   input  logic [2*bcs_pkg::WORD_W-1:0]    req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] estimate, [31:16] reading
   output logic [2*bcs_pkg::WORD_W-1:0]    rsp_tdata,
   // [0] reading_sane, [1] recalibrate
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_wr_en,
   input  logic [bcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcs_pkg::WEIGHT_W-1:0]    csr_wdata
);
   import bcs_pkg::*;

   // Configuration registers
   logic [WORD_W-1:0]   offset_coeff_ff, pressure_gain_ff, temp_gain_ff, cross_coeff_ff;
   logic [WORD_W-1:0]   sane_low_ff, sane_high_ff;
   logic [WEIGHT_W-1:0] keep_weight_ff;

   // Control
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   est_ff, est_in;

   // Datapath
   logic [2*SAMPLE_W-1:0]      tp_sh_ff, tp_sh_in;     // T bits above P bits
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [CROSS_W-1:0]  cross_ff, cross_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [DVS_W-1:0]           dvs_ff, dvs_in;
   logic [WORD_W-1:0]          quo_ff, quo_in;         // quotient, then reading shifter
   logic                       under_ff, under_in, over_ff, over_in;
   logic [WORD_W-1:0]          reading_ff, reading_in;
   logic [WORD_W-1:0]          old_sh_ff, old_sh_in;
   logic                       sane_ff, sane_in, mix_ff, mix_in;
   logic [BLEND_W-1:0]         bacc_ff, bacc_in;
   logic [WORD_W-1:0]          rsp_reading_ff, rsp_reading_in;
   logic                       rsp_sane_ff, rsp_sane_in;

   // Decoded coefficients
   logic signed [WORD_W:0]     temp_gain_s;     // b2 numerator: w - 65536
   logic signed [WORD_W-1:0]   pressure_gain_s; // b1 numerator
   logic signed [CROSS_W-1:0]  cross_add;
   logic signed [ACC_W-1:0]    mult_addend;
   logic                       serial_bit, t_phase;

   logic signed [SCALED_W-1:0] acc_wide, scaled;
   logic [REM_W-1:0]           dvs_wide;
   logic                       take;
   logic [WORD_W-1:0]          rd_sat;

   logic [WEIGHT_W-1:0]        keep_eff, keep_comp;
   logic [BLEND_W:0]           blend_sum;
   logic [WORD_W-1:0]          blended;
   logic                       out_free;

   assign temp_gain_s     = {1'b1, temp_gain_ff};
   assign pressure_gain_s = {PGAIN_BIAS_HI, pressure_gain_ff[PGAIN_FRAC_W-1:0]};
   assign cross_add       = signed'(CROSS_W'(cross_coeff_ff));

   // MSB-first shift-add: T bits first (b2 and c12 terms), then P bits (b1 + c12*T term)
   assign serial_bit  = tp_sh_ff[2*SAMPLE_W-1];
   assign t_phase     = (cnt_ff < T_STEPS);
   assign mult_addend = t_phase ? ACC_W'(temp_gain_s) : ACC_W'(cross_ff);

   // Scale by 65 and fold in the rounding half and the 50 kPa offset
   assign acc_wide = SCALED_W'(acc_ff);
   assign scaled   = (acc_wide <<< SCALE_NUM_SHIFT) + acc_wide + SCALE_BIAS;

   // Restoring division, one quotient bit a cycle
   assign dvs_wide = REM_W'(dvs_ff);
   assign take     = (rem_ff >= dvs_wide);

   assign rd_sat = under_ff ? '0 : (over_ff ? '1 : quo_ff);

   // Clamp the weight at one
   assign keep_eff  = (keep_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : keep_weight_ff;
   assign keep_comp = WEIGHT_ONE - keep_eff;
   assign blend_sum = {1'b0, bacc_ff} + BLEND_HALF;
   assign blended   = blend_sum[WORD_W +: WORD_W];

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      est_in         = est_ff;
      tp_sh_in       = tp_sh_ff;
      acc_in         = acc_ff;
      cross_in       = cross_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      quo_in         = quo_ff;
      under_in       = under_ff;
      over_in        = over_ff;
      reading_in     = reading_ff;
      old_sh_in      = old_sh_ff;
      sane_in        = sane_ff;
      mix_in         = mix_ff;
      bacc_in        = bacc_ff;
      rsp_reading_in = rsp_reading_ff;
      rsp_sane_in    = rsp_sane_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               tp_sh_in = {req_tdata[2*WORD_W-1 -: SAMPLE_W], req_tdata[WORD_W-1 -: SAMPLE_W]};
               // Preloads come out multiplied by 2^10 after the ten T steps
               acc_in   = signed'(ACC_W'(offset_coeff_ff) << 1);
               cross_in = CROSS_W'(pressure_gain_s) <<< 1;
               cnt_in   = '0;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            acc_in   = (acc_ff <<< 1) + (serial_bit ? mult_addend : '0);
            if (t_phase) begin
               cross_in = (cross_ff <<< 1) + (serial_bit ? cross_add : '0);
            end
            tp_sh_in = tp_sh_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MULT_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            rem_in   = scaled[REM_W-1:0];
            under_in = scaled[SCALED_W-1];
            over_in  = !scaled[SCALED_W-1] && ($unsigned(scaled) >= SAT_LIMIT);
            dvs_in   = DVS_START;
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in = take ? (rem_ff - dvs_wide) : rem_ff;
            quo_in = {quo_ff[WORD_W-2:0], take};
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WORD_LAST) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            reading_in = rd_sat;
            quo_in     = rd_sat;
            old_sh_in  = est_ff;
            sane_in    = (rd_sat > sane_low_ff) && (rd_sat < sane_high_ff);
            mix_in     = sane_in && (est_ff > sane_low_ff) && (est_ff < sane_high_ff);
            bacc_in    = '0;
            cnt_in     = '0;
            state_in   = mix_in ? ST_BLEND : ST_FINISH;
         end
         ST_BLEND: begin
            bacc_in   = (bacc_ff << 1)
                      + (old_sh_ff[WORD_W-1] ? BLEND_W'(keep_eff) : '0)
                      + (quo_ff[WORD_W-1] ? BLEND_W'(keep_comp) : '0);
            old_sh_in = old_sh_ff << 1;
            quo_in    = quo_ff << 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == WORD_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the previous result has left
            if (out_free) begin
               if (mix_ff) begin
                  est_in = blended;
               end else if (sane_ff) begin
                  est_in = reading_ff;
               end
               rsp_reading_in = reading_ff;
               rsp_sane_in    = sane_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         est_ff           <= '0;
         offset_coeff_ff  <= '0;
         pressure_gain_ff <= '0;
         temp_gain_ff     <= '0;
         cross_coeff_ff   <= '0;
         sane_low_ff      <= SANE_LOW_RESET;
         sane_high_ff     <= SANE_HIGH_RESET;
         keep_weight_ff   <= KEEP_WEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff       <= est_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_OFFSET_COEFF:  offset_coeff_ff  <= csr_wdata[WORD_W-1:0];
               CSR_PRESSURE_GAIN: pressure_gain_ff <= csr_wdata[WORD_W-1:0];
               CSR_TEMP_GAIN:     temp_gain_ff     <= csr_wdata[WORD_W-1:0];
               CSR_CROSS_COEFF:   cross_coeff_ff   <= csr_wdata[WORD_W-1:0];
               CSR_SANE_LOW:      sane_low_ff      <= csr_wdata[WORD_W-1:0];
               CSR_SANE_HIGH:     sane_high_ff     <= csr_wdata[WORD_W-1:0];
               CSR_KEEP_WEIGHT:   keep_weight_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tp_sh_ff       <= tp_sh_in;
      acc_ff         <= acc_in;
      cross_ff       <= cross_in;
      rem_ff         <= rem_in;
      dvs_ff         <= dvs_in;
      quo_ff         <= quo_in;
      under_ff       <= under_in;
      over_ff        <= over_in;
      reading_ff     <= reading_in;
      old_sh_ff      <= old_sh_in;
      sane_ff        <= sane_in;
      mix_ff         <= mix_in;
      bacc_ff        <= bacc_in;
      rsp_reading_ff <= rsp_reading_in;
      rsp_sane_ff    <= rsp_sane_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_reading_ff, est_ff};
   assign rsp_tuser  = {!rsp_sane_ff, rsp_sane_ff};

   // Divider keeps the remainder below twice the current divisor when in range
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && !under_ff && !over_ff |-> rem_ff < {dvs_ff, 1'b0})
      else $error("divider remainder out of range");

   // Estimate moves only when a result is loaded
   a_est_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FINISH) |=> $stable(est_ff))
      else $error("estimate changed outside finish step");

   // A sane reading leaves the estimate inside the bounds
   a_est_sane: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && out_free && sane_ff |=>
         (est_ff > $past(sane_low_ff)) && (est_ff < $past(sane_high_ff)))
      else $error("estimate left sanity bounds");

endmodule
